### sv/sfjs_pkg.sv
`default_nettype none
package sfjs_pkg;
	localparam int MAX_SERVERS = 32;
	localparam int NUM_CLASSES = 8;
	localparam int FIFO_DEPTH = 64;
	localparam int CW = $clog2(MAX_SERVERS);
	localparam int FW = $clog2(FIFO_DEPTH);
	localparam logic [6:0] WAIT_MAX = 7'd127;
	localparam logic [5:0] RUN_MAX = 6'd63;
	localparam logic [6:0] NEED_MAX = 7'd127;
	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_DEPART = 1'b1;
	localparam logic [0:0] REG_TOTAL = 1'b0;

	typedef struct packed {
		logic        op;
		logic [2:0]  job_class;
		logic [5:0]  job_size;
		logic [31:0] job_id;
	} sfjs_in_t;

	typedef struct packed {
		logic        rescheduled;
		logic        entry_valid;
		logic [31:0] entry_id;
		logic [2:0]  entry_class;
		logic        entry_running;
		logic [5:0]  servers_left;
		logic        dropped;
		logic        last;
	} sfjs_out_t;

	typedef struct packed {
		logic [2:0]  cls;
		logic [5:0]  size;
		logic [31:0] id;
	} job_t;
endpackage
`default_nettype wire

### sv/server_filling_job_scheduler_top.sv
// Server-filling multiserver job scheduler.
// in channel (in_valid/in_ready, payload in_data): one event request, an
// arrival (op 0) or a departure (op 1) of a job of given class, size and id.
// out channel (out_valid/out_ready, payload out_data): one result per
// candidate entry in set order after the event, or a single empty result;
// last marks the final result of the event.
// APB port: register 0 at byte address 0 is total_servers (reset 32).
// The block handles one event at a time. Candidate entries live in a
// single-port memory with a registered read; every pass over the set
// (departure compaction, each insertion, greedy fill, report) reads each
// entry in one state and writes or uses it in the next. The set holds up
// to 32 candidates; each job moved in from the buffer costs one more
// insertion pass, and a refill may move a whole set in.
// The next request is taken once the final result has left the output
// register. A stalled receiver holds the report walk and nothing is lost.
// Reset empties buffer and set, clears the class counts and sets free
// servers to 32; no memory clearing pass is used.
`default_nettype none
module server_filling_job_scheduler_top import sfjs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire sfjs_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output sfjs_out_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [0:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_RMRD  = 11'b00000000010,
		S_RMWR  = 11'b00000000100,
		S_MOVE  = 11'b00000001000,
		S_INSRD = 11'b00000010000,
		S_INSWR = 11'b00000100000,
		S_FILRD = 11'b00001000000,
		S_FILWR = 11'b00010000000,
		S_REPRD = 11'b00100000000,
		S_REPWT = 11'b01000000000,
		S_CLS   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [5:0] total_q;
	job_t fifo_mem [FIFO_DEPTH];
	job_t fifo_rd_q;
	logic [FW-1:0] head_q;
	logic [FW:0] fcount_q;
	job_t cand_mem [MAX_SERVERS];
	logic [MAX_SERVERS-1:0] run_q;
	job_t cand_rd_q;
	logic [CW:0] ccount_q;
	logic [6:0] need_q;
	logic [5:0] free_q;
	logic [6:0] cwait_q [NUM_CLASSES];
	logic [5:0] crun_q [NUM_CLASSES];
	sfjs_in_t cur_q;
	logic [CW:0] rd_q, wr_q;
	logic resched_q, dropped_q, fifo_rd_pend_q, placed_q;
	job_t carry_q;
	logic carry_run_q;
	logic [5:0] srv;

	// register port
	assign pready = 1'b1;
	assign prdata = {26'd0, total_q};
	assign srv = (total_q > 6'(MAX_SERVERS)) ? 6'(MAX_SERVERS) : total_q;
	assign in_ready = (state_q == S_IDLE) && !out_valid;

	// candidate memory: one access per cycle
	logic cm_we;
	logic [CW-1:0] cm_addr;
	job_t cm_wd;
	always_ff @(posedge clk) begin
		if (cm_we) cand_mem[cm_addr] <= cm_wd;
		else cand_rd_q <= cand_mem[cm_addr];
	end

	logic fm_we;
	logic [FW-1:0] fm_tail;
	assign fm_tail = head_q + fcount_q[FW-1:0];
	assign fm_we = in_valid && in_ready && in_data.op == OP_ARRIVE &&
		fcount_q < (FW+1)'(FIFO_DEPTH);
	always_ff @(posedge clk) begin
		if (fm_we) fifo_mem[fm_tail] <= '{in_data.job_class, in_data.job_size, in_data.job_id};
		fifo_rd_q <= fifo_mem[head_q];
	end

	// memory address and write data per state
	always_comb begin
		cm_we = 1'b0;
		cm_addr = rd_q[CW-1:0];
		cm_wd = cand_rd_q;
		unique case (state_q)
			S_RMWR: begin
				cm_we = (cand_rd_q.id != cur_q.job_id);
				cm_addr = wr_q[CW-1:0];
			end
			S_INSWR: begin
				cm_we = 1'b1;
				cm_addr = wr_q[CW-1:0];
				cm_wd = (!placed_q && (rd_q == ccount_q || carry_q.size > cand_rd_q.size))
					? carry_q : cand_rd_q;
				if (placed_q) cm_wd = carry_q;
			end
			default: ;
		endcase
	end

	// event sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= 6'd32;
			head_q <= '0;
			fcount_q <= '0;
			run_q <= '0;
			ccount_q <= '0;
			need_q <= '0;
			free_q <= 6'd32;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				cwait_q[c] <= '0;
				crun_q[c] <= '0;
			end
			out_valid <= 1'b0;
			out_data <= '0;
			cur_q <= '0;
			carry_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			resched_q <= 1'b0;
			dropped_q <= 1'b0;
			fifo_rd_pend_q <= 1'b0;
			placed_q <= 1'b0;
			carry_run_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_TOTAL)
				total_q <= pwdata[5:0];
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					cur_q <= in_data;
					resched_q <= 1'b0;
					dropped_q <= 1'b0;
					rd_q <= '0;
					wr_q <= '0;
					if (in_data.op == OP_ARRIVE) begin
						if (fcount_q >= (FW+1)'(FIFO_DEPTH)) begin
							dropped_q <= 1'b1;
							state_q <= S_REPRD;
						end else begin
							fcount_q <= fcount_q + 1'b1;
							if (int'(in_data.job_class) < NUM_CLASSES &&
								cwait_q[in_data.job_class] < WAIT_MAX)
								cwait_q[in_data.job_class] <= cwait_q[in_data.job_class] + 1'b1;
							state_q <= (free_q != 0) ? S_CLS : S_REPRD;
						end
					end else begin
						if (int'(in_data.job_class) < NUM_CLASSES &&
							crun_q[in_data.job_class] != 0)
							crun_q[in_data.job_class] <= crun_q[in_data.job_class] - 1'b1;
						free_q <= (7'(free_q) + 7'(in_data.job_size) > 7'd63) ? 6'd63
							: free_q + in_data.job_size;
						need_q <= (need_q > 7'(in_data.job_size))
							? need_q - 7'(in_data.job_size) : 7'd0;
						// refill only if some server is free after the release
						state_q <= (ccount_q != 0) ? S_RMRD
							: ((free_q != 0 || in_data.job_size != 0) ? S_CLS : S_REPRD);
					end
				end
				// compaction: read entry, keep if id differs
				S_RMRD: state_q <= S_RMWR;
				S_RMWR: begin
					if (cand_rd_q.id != cur_q.job_id) begin
						run_q[wr_q[CW-1:0]] <= run_q[rd_q[CW-1:0]];
						wr_q <= wr_q + 1'b1;
					end
					if (rd_q + 1'b1 == ccount_q) begin
						ccount_q <= (cand_rd_q.id != cur_q.job_id) ? wr_q + 1'b1 : wr_q;
						rd_q <= '0;
						state_q <= (free_q != 0) ? S_CLS : S_REPRD;
					end else begin
						rd_q <= rd_q + 1'b1;
						state_q <= S_RMRD;
					end
				end
				// refill start: fold running counts into waiting
				S_CLS: begin
					resched_q <= 1'b1;
					for (int c = 0; c < NUM_CLASSES; c++)
						cwait_q[c] <= (8'(cwait_q[c]) + 8'(crun_q[c]) > 8'(WAIT_MAX))
							? WAIT_MAX : cwait_q[c] + 7'(crun_q[c]);
					fifo_rd_pend_q <= 1'b1;
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					if (fifo_rd_pend_q) fifo_rd_pend_q <= 1'b0;
					else if (need_q < 7'(srv) && fcount_q != 0 &&
						ccount_q < (CW+1)'(MAX_SERVERS)) begin
						carry_q <= fifo_rd_q;
						carry_run_q <= 1'b0;
						placed_q <= 1'b0;
						head_q <= head_q + 1'b1;
						fcount_q <= fcount_q - 1'b1;
						need_q <= (8'(need_q) + 8'(fifo_rd_q.size) > 8'(NEED_MAX))
							? NEED_MAX : need_q + 7'(fifo_rd_q.size);
						rd_q <= '0;
						wr_q <= '0;
						state_q <= S_INSRD;
					end else begin
						free_q <= srv;
						for (int c = 0; c < NUM_CLASSES; c++) crun_q[c] <= '0;
						rd_q <= '0;
						state_q <= (ccount_q != 0) ? S_FILRD : S_REPRD;
					end
				end
				// insertion: rewrite the set, shifting a carried entry down
				S_INSRD: state_q <= S_INSWR;
				S_INSWR: begin
					if (placed_q || rd_q == ccount_q || carry_q.size > cand_rd_q.size) begin
						run_q[wr_q[CW-1:0]] <= carry_run_q;
						if (rd_q != ccount_q) begin
							carry_q <= cand_rd_q;
							carry_run_q <= run_q[rd_q[CW-1:0]];
						end
						placed_q <= 1'b1;
					end
					if (rd_q == ccount_q) begin
						ccount_q <= ccount_q + 1'b1;
						fifo_rd_pend_q <= 1'b1;
						state_q <= S_MOVE;
					end else begin
						rd_q <= rd_q + 1'b1;
						wr_q <= wr_q + 1'b1;
						state_q <= S_INSRD;
					end
				end
				// greedy fill in set order
				S_FILRD: state_q <= S_FILWR;
				S_FILWR: begin
					if (cand_rd_q.size <= free_q) begin
						run_q[rd_q[CW-1:0]] <= 1'b1;
						free_q <= free_q - cand_rd_q.size;
						if (int'(cand_rd_q.cls) < NUM_CLASSES) begin
							if (crun_q[cand_rd_q.cls] < RUN_MAX)
								crun_q[cand_rd_q.cls] <= crun_q[cand_rd_q.cls] + 1'b1;
							if (cwait_q[cand_rd_q.cls] != 0)
								cwait_q[cand_rd_q.cls] <= cwait_q[cand_rd_q.cls] - 1'b1;
						end
					end else run_q[rd_q[CW-1:0]] <= 1'b0;
					if (rd_q + 1'b1 == ccount_q) begin
						rd_q <= '0;
						state_q <= S_REPRD;
					end else begin
						rd_q <= rd_q + 1'b1;
						state_q <= S_FILRD;
					end
				end
				// report: one result per entry through the output register
				S_REPRD: if (!out_valid || out_ready) state_q <= S_REPWT;
				S_REPWT: begin
					out_valid <= 1'b1;
					out_data.rescheduled <= resched_q;
					out_data.entry_valid <= (ccount_q != 0);
					out_data.entry_id <= (ccount_q != 0) ? cand_rd_q.id : '0;
					out_data.entry_class <= (ccount_q != 0) ? cand_rd_q.cls : '0;
					out_data.entry_running <= (ccount_q != 0) ? run_q[rd_q[CW-1:0]] : 1'b0;
					out_data.servers_left <= free_q;
					out_data.dropped <= dropped_q;
					if (rd_q + 1'b1 >= ccount_q) begin
						out_data.last <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						out_data.last <= 1'b0;
						rd_q <= rd_q + 1'b1;
						state_q <= S_REPRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
